// ----- rtl/qalu_pkg.sv -----
// Package for the quaternion ALU: widths, opcodes, status codes, pipeline
// structures, the Hamilton product term tables and the saturation helper.
// No dependencies; every other file uses it through scoped names.
package qalu_pkg;

    // Component format: signed fixed point with FB fraction bits.
    localparam int CW   = 32;
    localparam int FB   = 16;

    // Derived widths.
    localparam int NW   = CW + FB;       // dividend magnitude |c| * 2^FB
    localparam int SQW  = 2 * CW - 1;    // square of a component magnitude
    localparam int SUMW = 2 * CW + 1;    // sum of four squares
    localparam int DW   = SUMW - FB;     // divisor and partial remainder
    localparam int RB   = CW - 1;        // square root result bits
    localparam int SRW  = RB + 3;        // square root partial remainder
    localparam int PW   = 2 * CW;        // signed product
    localparam int ACCW = PW + 2;        // sum of four products

    // Stream widths.
    localparam int IN_RAW  = 4 + 9 * CW;
    localparam int IN_W    = ((IN_RAW + 7) / 8) * 8;
    localparam int OUT_RAW = 4 * CW + (CW - 1) + 2;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

    // Opcodes.
    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_MUL   = 4'd2;
    localparam logic [3:0] OP_DIV   = 4'd3;
    localparam logic [3:0] OP_SCALE = 4'd4;
    localparam logic [3:0] OP_DIVS  = 4'd5;
    localparam logic [3:0] OP_SOVQ  = 4'd6;
    localparam logic [3:0] OP_CONJ  = 4'd7;
    localparam logic [3:0] OP_INV   = 4'd8;
    localparam logic [3:0] OP_NORM  = 4'd9;

    // Status codes.
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_DZ  = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    // Hamilton product: output j is the signed sum over k of
    // a[AIDX[j][k]] * b[BIDX[j][k]], the term negated where NEG is set.
    localparam logic [1:0] AIDX [0:3][0:3] = '{
        '{2'd1, 2'd2, 2'd0, 2'd3},
        '{2'd2, 2'd0, 2'd1, 2'd3},
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd3, 2'd0, 2'd1, 2'd2}};
    localparam logic [1:0] BIDX [0:3][0:3] = '{
        '{2'd2, 2'd1, 2'd3, 2'd0},
        '{2'd0, 2'd2, 2'd3, 2'd1},
        '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd3, 2'd0, 2'd1, 2'd2}};
    localparam logic NEG [0:3][0:3] = '{
        '{1'b0, 1'b1, 1'b0, 1'b0},
        '{1'b0, 1'b1, 1'b0, 1'b0},
        '{1'b0, 1'b1, 1'b0, 1'b0},
        '{1'b0, 1'b1, 1'b1, 1'b1}};

    typedef struct packed {
        logic [3:0]         op;
        logic [3:0][CW-1:0] q;
        logic [3:0][CW-1:0] r;
        logic [CW-1:0]      sc;
    } in_t;

    // Item as carried down the pipeline, with the add, subtract and
    // conjugate results already formed.
    typedef struct packed {
        logic [3:0]         op;
        logic [3:0][CW-1:0] q;
        logic [3:0][CW-1:0] r;
        logic [CW-1:0]      sc;
        logic [3:0][CW-1:0] easy;
        logic               easy_sat;
    } item_t;

    typedef struct packed {
        item_t               item;
        logic [3:0][SQW-1:0] sq;
        logic [3:0][CW-1:0]  cmag;
        logic [3:0]          cneg;
    } p1_t;

    typedef struct packed {
        item_t              item;
        logic [SUMW-1:0]    sum;
        logic [3:0][CW-1:0] cmag;
        logic [3:0]         cneg;
    } p2_t;

    // One stage of the shared divide and square root pipeline.
    typedef struct packed {
        item_t              item;
        logic [DW-1:0]      dvs;
        logic               dz;
        logic [3:0][DW-1:0] rem;
        logic [3:0][CW-1:0] nlo;
        logic [3:0][CW-1:0] quo;
        logic [3:0]         neg;
        logic [3:0]         ovf;
        logic [SRW-1:0]     srem;
        logic [RB-1:0]      root;
        logic [2*RB-1:0]    sx;
        logic               nsat;
    } ds_t;

    typedef struct packed {
        item_t              item;
        logic [3:0][CW-1:0] t;
        logic               invsat;
        logic               dz;
        logic [RB-1:0]      root;
        logic               nsat;
    } fin_t;

    typedef struct packed {
        logic [3:0]               op;
        logic [3:0][CW-1:0]       easy;
        logic                     easy_sat;
        logic [3:0][CW-1:0]       t;
        logic                     invsat;
        logic                     dz;
        logic [RB-1:0]            root;
        logic                     nsat;
        logic [3:0][3:0][PW-1:0]  prod;
        logic [3:0][3:0]          pneg;
    } mul_t;

    typedef struct packed {
        logic [3:0][CW-1:0] res;
        logic [CW-2:0]      norm;
        logic [1:0]         status;
    } res_t;

    typedef struct packed {
        logic [CW-1:0] val;
        logic          hit;
    } sat_t;

    // Clamp a wide signed value to the component range.
    function automatic sat_t sat_fn(input logic signed [ACCW-1:0] v);
        sat_t                   o;
        logic signed [ACCW-1:0] maxv;
        logic signed [ACCW-1:0] minv;
        maxv = {{(ACCW-CW+1){1'b0}}, {(CW-1){1'b1}}};
        minv = ~maxv;
        o.hit = 1'b1;
        if (v > maxv)
        begin
            o.val = maxv[CW-1:0];
        end
        else if (v < minv)
        begin
            o.val = minv[CW-1:0];
        end
        else
        begin
            o.val = v[CW-1:0];
            o.hit = 1'b0;
        end
        return o;
    endfunction

endpackage

// ----- rtl/qalu_prep.sv -----
// Front of the quaternion ALU pipeline: simple results, squares, sum of
// squares and divider set-up, over three register stages. Uses qalu_pkg.
module qalu_prep (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_vld,
    input  qalu_pkg::in_t   din,
    output logic            out_vld,
    output qalu_pkg::ds_t   dout
);

    logic          p1_vld_reg;
    logic          p2_vld_reg;
    logic          p3_vld_reg;
    qalu_pkg::p1_t p1_reg;
    qalu_pkg::p1_t p1_next;
    qalu_pkg::p2_t p2_reg;
    qalu_pkg::p2_t p2_next;
    qalu_pkg::ds_t p3_reg;
    qalu_pkg::ds_t p3_next;

    // Stage one: easy results, operand magnitudes and their squares.
    always_comb
    begin
        logic [qalu_pkg::CW-1:0]          v;
        logic [qalu_pkg::CW-1:0]          vmag;
        logic [2*qalu_pkg::CW-1:0]        sqf;
        logic signed [qalu_pkg::ACCW-1:0] ea;
        logic signed [qalu_pkg::ACCW-1:0] qa;
        logic signed [qalu_pkg::ACCW-1:0] ra;
        qalu_pkg::sat_t                   es;
        p1_next.item.op       = din.op;
        p1_next.item.q        = din.q;
        p1_next.item.r        = din.r;
        p1_next.item.sc       = din.sc;
        p1_next.item.easy_sat = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            qa = qalu_pkg::ACCW'(signed'(din.q[k]));
            ra = qalu_pkg::ACCW'(signed'(din.r[k]));
            case (din.op)
                qalu_pkg::OP_ADD:  ea = qa + ra;
                qalu_pkg::OP_SUB:  ea = qa - ra;
                qalu_pkg::OP_CONJ: ea = (k < 3) ? -qa : qa;
                default:           ea = '0;
            endcase
            es = qalu_pkg::sat_fn(ea);
            p1_next.item.easy[k]  = es.val;
            p1_next.item.easy_sat = p1_next.item.easy_sat | es.hit;

            v    = (din.op == qalu_pkg::OP_DIV) ? din.r[k] : din.q[k];
            vmag = v[qalu_pkg::CW-1] ? -v : v;
            sqf  = vmag * vmag;
            p1_next.sq[k]   = sqf[qalu_pkg::SQW-1:0];
            p1_next.cmag[k] = vmag;
            // The inverse divides the conjugate, so x, y and z change sign.
            if (din.op != qalu_pkg::OP_DIVS && k < 3)
            begin
                p1_next.cneg[k] = ~v[qalu_pkg::CW-1];
            end
            else
            begin
                p1_next.cneg[k] = v[qalu_pkg::CW-1];
            end
        end
    end

    // Stage two: sum of the four squares.
    always_comb
    begin
        p2_next.item = p1_reg.item;
        p2_next.cmag = p1_reg.cmag;
        p2_next.cneg = p1_reg.cneg;
        p2_next.sum  = '0;
        for (int k = 0; k < 4; k++)
        begin
            p2_next.sum = p2_next.sum + qalu_pkg::SUMW'(p1_reg.sq[k]);
        end
    end

    // Stage three: divisor, dividends, overflow pre-check and root input.
    always_comb
    begin
        logic [qalu_pkg::CW-1:0] scmag;
        logic [qalu_pkg::NW-1:0] nfull;
        logic                    is_divs;
        is_divs = (p2_reg.item.op == qalu_pkg::OP_DIVS);
        scmag   = p2_reg.item.sc[qalu_pkg::CW-1] ? -p2_reg.item.sc : p2_reg.item.sc;
        p3_next.item = p2_reg.item;
        p3_next.dvs  = is_divs ? qalu_pkg::DW'(scmag)
                               : p2_reg.sum[qalu_pkg::SUMW-1:qalu_pkg::FB];
        p3_next.dz   = (p2_reg.item.op inside {qalu_pkg::OP_DIV, qalu_pkg::OP_SOVQ,
                                               qalu_pkg::OP_INV, qalu_pkg::OP_DIVS})
                       && (p3_next.dvs == '0);
        for (int k = 0; k < 4; k++)
        begin
            nfull = {p2_reg.cmag[k], {qalu_pkg::FB{1'b0}}};
            p3_next.rem[k] = qalu_pkg::DW'(nfull[qalu_pkg::NW-1:qalu_pkg::CW]);
            p3_next.nlo[k] = nfull[qalu_pkg::CW-1:0];
            p3_next.quo[k] = '0;
            p3_next.ovf[k] = (p3_next.rem[k] >= p3_next.dvs);
            p3_next.neg[k] = p2_reg.cneg[k]
                             ^ (is_divs & p2_reg.item.sc[qalu_pkg::CW-1]);
        end
        p3_next.srem = '0;
        p3_next.root = '0;
        p3_next.sx   = p2_reg.sum[2*qalu_pkg::RB-1:0];
        p3_next.nsat = |p2_reg.sum[qalu_pkg::SUMW-1:2*qalu_pkg::RB];
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_vld_reg <= in_vld;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
        end
    end

    // Data registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            p3_reg <= p3_next;
        end
    end

    assign out_vld = p3_vld_reg;
    assign dout    = p3_reg;

endmodule

// ----- rtl/qalu_divsqrt.sv -----
// Shared restoring divide (four lanes, one quotient bit per stage) and
// digit-by-digit square root (one root bit per stage). Uses qalu_pkg.
module qalu_divsqrt (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_vld,
    input  qalu_pkg::ds_t   din,
    output logic            out_vld,
    output qalu_pkg::ds_t   dout
);

    localparam int NS = qalu_pkg::CW;

    logic [NS-1:0] vld_reg;
    qalu_pkg::ds_t st_reg [NS];

    // One quotient bit for each of the four lanes.
    function automatic qalu_pkg::ds_t div_step(input qalu_pkg::ds_t a);
        qalu_pkg::ds_t           o;
        logic [qalu_pkg::DW:0]   t;
        logic                    ge;
        o = a;
        for (int k = 0; k < 4; k++)
        begin
            t  = {a.rem[k], a.nlo[k][qalu_pkg::CW-1]};
            ge = (t >= {1'b0, a.dvs});
            if (ge)
            begin
                t = t - {1'b0, a.dvs};
            end
            o.rem[k] = t[qalu_pkg::DW-1:0];
            o.nlo[k] = {a.nlo[k][qalu_pkg::CW-2:0], 1'b0};
            o.quo[k] = {a.quo[k][qalu_pkg::CW-2:0], ge};
        end
        return o;
    endfunction

    // One bit of the integer square root.
    function automatic qalu_pkg::ds_t sqrt_step(input qalu_pkg::ds_t a);
        qalu_pkg::ds_t          o;
        logic [qalu_pkg::SRW-1:0] t;
        logic [qalu_pkg::SRW-1:0] trial;
        o     = a;
        t     = {a.srem[qalu_pkg::RB:0], a.sx[2*qalu_pkg::RB-1 -: 2]};
        trial = qalu_pkg::SRW'({a.root, 2'b01});
        o.sx  = {a.sx[2*qalu_pkg::RB-3:0], 2'b00};
        if (t >= trial)
        begin
            o.srem = t - trial;
            o.root = {a.root[qalu_pkg::RB-2:0], 1'b1};
        end
        else
        begin
            o.srem = t;
            o.root = {a.root[qalu_pkg::RB-2:0], 1'b0};
        end
        return o;
    endfunction

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        localparam bit DO_SQRT = (s < qalu_pkg::RB);
        qalu_pkg::ds_t cur;
        qalu_pkg::ds_t nxt;
        logic          cur_vld;

        if (s == 0)
        begin : g_first
            assign cur     = din;
            assign cur_vld = in_vld;
        end
        else
        begin : g_next
            assign cur     = st_reg[s-1];
            assign cur_vld = vld_reg[s-1];
        end

        // Divide bit, then a root bit while root bits remain.
        always_comb
        begin
            nxt = div_step(cur);
            if (DO_SQRT)
            begin
                nxt = sqrt_step(nxt);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= cur_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[s] <= nxt;
            end
        end
    end

    assign out_vld = vld_reg[NS-1];
    assign dout    = st_reg[NS-1];

endmodule

// ----- rtl/qalu_mul.sv -----
// Back of the quaternion ALU pipeline: quotient sign and saturation, the
// sixteen products of the Hamilton product or scaling, and the final sum,
// clamp and result selection. Uses qalu_pkg.
module qalu_mul (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_vld,
    input  qalu_pkg::ds_t   din,
    output logic            out_vld,
    output qalu_pkg::res_t  dout
);

    logic           f_vld_reg;
    logic           m_vld_reg;
    logic           s_vld_reg;
    qalu_pkg::fin_t f_reg;
    qalu_pkg::fin_t f_next;
    qalu_pkg::mul_t m_reg;
    qalu_pkg::mul_t m_next;
    qalu_pkg::res_t s_reg;
    qalu_pkg::res_t s_next;

    // Finish the quotients: apply the sign and clamp to the component range.
    always_comb
    begin
        logic [qalu_pkg::CW-1:0] mag;
        logic [qalu_pkg::CW-1:0] half;
        half          = {1'b1, {(qalu_pkg::CW-1){1'b0}}};
        f_next.item   = din.item;
        f_next.dz     = din.dz;
        f_next.root   = din.root;
        f_next.nsat   = din.nsat;
        f_next.invsat = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            mag = din.quo[k];
            if (din.neg[k])
            begin
                if (din.ovf[k] || mag > half)
                begin
                    f_next.t[k]   = half;
                    f_next.invsat = 1'b1;
                end
                else
                begin
                    f_next.t[k] = -mag;
                end
            end
            else
            begin
                if (din.ovf[k] || mag[qalu_pkg::CW-1])
                begin
                    f_next.t[k]   = ~half;
                    f_next.invsat = 1'b1;
                end
                else
                begin
                    f_next.t[k] = mag;
                end
            end
        end
    end

    // Products: Hamilton terms, or one scaling term per component.
    always_comb
    begin
        logic signed [qalu_pkg::CW-1:0] ma;
        logic signed [qalu_pkg::CW-1:0] mb;
        logic signed [qalu_pkg::PW-1:0] p;
        logic [3:0][qalu_pkg::CW-1:0]   bq;
        logic [3:0][qalu_pkg::CW-1:0]   sq;
        logic                           scl;
        m_next.op       = f_reg.item.op;
        m_next.easy     = f_reg.item.easy;
        m_next.easy_sat = f_reg.item.easy_sat;
        m_next.t        = f_reg.t;
        m_next.invsat   = f_reg.invsat;
        m_next.dz       = f_reg.dz;
        m_next.root     = f_reg.root;
        m_next.nsat     = f_reg.nsat;
        bq  = (f_reg.item.op == qalu_pkg::OP_MUL) ? f_reg.item.r : f_reg.t;
        sq  = (f_reg.item.op == qalu_pkg::OP_SCALE) ? f_reg.item.q : f_reg.t;
        scl = (f_reg.item.op == qalu_pkg::OP_SCALE) || (f_reg.item.op == qalu_pkg::OP_SOVQ);
        for (int j = 0; j < 4; j++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                if (scl)
                begin
                    ma = (k == 0) ? signed'(sq[j]) : '0;
                    mb = signed'(f_reg.item.sc);
                    m_next.pneg[j][k] = 1'b0;
                end
                else
                begin
                    ma = signed'(f_reg.item.q[qalu_pkg::AIDX[j][k]]);
                    mb = signed'(bq[qalu_pkg::BIDX[j][k]]);
                    m_next.pneg[j][k] = qalu_pkg::NEG[j][k];
                end
                p = ma * mb;
                m_next.prod[j][k] = p;
            end
        end
    end

    // Sum, floor shift, clamp and pick the result for the opcode.
    always_comb
    begin
        logic signed [qalu_pkg::ACCW-1:0] acc;
        logic signed [qalu_pkg::ACCW-1:0] pe;
        logic [3:0][qalu_pkg::CW-1:0]     ham;
        logic                             hsat;
        logic                             satf;
        qalu_pkg::sat_t                   st;
        hsat = 1'b0;
        for (int j = 0; j < 4; j++)
        begin
            acc = '0;
            for (int k = 0; k < 4; k++)
            begin
                pe  = qalu_pkg::ACCW'(signed'(m_reg.prod[j][k]));
                acc = m_reg.pneg[j][k] ? acc - pe : acc + pe;
            end
            st     = qalu_pkg::sat_fn(acc >>> qalu_pkg::FB);
            ham[j] = st.val;
            hsat   = hsat | st.hit;
        end
        s_next.res  = '0;
        s_next.norm = '0;
        satf        = 1'b0;
        case (m_reg.op)
            qalu_pkg::OP_ADD, qalu_pkg::OP_SUB, qalu_pkg::OP_CONJ:
            begin
                s_next.res = m_reg.easy;
                satf       = m_reg.easy_sat;
            end
            qalu_pkg::OP_MUL, qalu_pkg::OP_SCALE:
            begin
                s_next.res = ham;
                satf       = hsat;
            end
            qalu_pkg::OP_DIV, qalu_pkg::OP_SOVQ:
            begin
                s_next.res = ham;
                satf       = hsat | m_reg.invsat;
            end
            qalu_pkg::OP_DIVS, qalu_pkg::OP_INV:
            begin
                s_next.res = m_reg.t;
                satf       = m_reg.invsat;
            end
            qalu_pkg::OP_NORM:
            begin
                s_next.norm = m_reg.nsat ? {(qalu_pkg::CW-1){1'b1}} : m_reg.root;
                satf        = m_reg.nsat;
            end
            default:
            begin
                satf = 1'b0;
            end
        endcase
        if (m_reg.dz)
        begin
            s_next.res    = '0;
            s_next.status = qalu_pkg::ST_DZ;
        end
        else
        begin
            s_next.status = satf ? qalu_pkg::ST_SAT : qalu_pkg::ST_OK;
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
            s_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            f_vld_reg <= in_vld;
            m_vld_reg <= f_vld_reg;
            s_vld_reg <= m_vld_reg;
        end
    end

    // Data registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_reg <= f_next;
            m_reg <= m_next;
            s_reg <= s_next;
        end
    end

    assign out_vld = s_vld_reg;
    assign dout    = s_reg;

endmodule

// ----- rtl/quaternion_alu.sv -----
// Quaternion ALU, signed fixed point, one result for every input transfer.
// Uses qalu_pkg, qalu_prep, qalu_divsqrt and qalu_mul.
//
// Usage:
//   The slave channel (s_tvalid, s_tready, s_tdata) takes one item per
//   transfer: an opcode, quaternions q and r and a scalar. The master channel
//   (m_tvalid, m_tready, m_tdata) returns the result quaternion, the norm and
//   a status code (ok, divide by zero, saturated) for each item, in order.
//   The item passes 39 register stages, the first loaded by the transfer
//   itself: three set-up stages, 32 stages of the shared divide and square
//   root pipeline (one quotient bit per stage, one root bit in every stage
//   but the last), three stages of quotient finishing, multiplication and
//   summing, and the output register.
//   Throughput is one item per cycle while the receiver keeps up; every
//   opcode travels the same pipeline, so results never reorder.
//   Reset clears all valid bits; the pipeline is empty and m_tvalid is low.
//   When the receiver stalls, the output register holds its result and the
//   pipeline freezes once its last stage is full; s_tready then drops until
//   the result is taken. No item is lost or repeated.
module quaternion_alu (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // action, q_x, q_y, q_z, q_w, r_x, r_y, r_z, r_w, scalar_in, zero padding
    input  logic [qalu_pkg::IN_W-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // res_x, res_y, res_z, res_w, norm_out, status, zero padding
    output logic [qalu_pkg::OUT_W-1:0]  m_tdata
);

    logic           en;
    logic           prep_vld;
    logic           ds_vld;
    logic           last_vld;
    logic           out_vld_reg;
    logic           out_vld_next;
    qalu_pkg::in_t  din;
    qalu_pkg::ds_t  prep_out;
    qalu_pkg::ds_t  ds_out;
    qalu_pkg::res_t last_res;
    qalu_pkg::res_t out_reg;

    // Unpack the input transfer.
    always_comb
    begin
        din.op = s_tdata[3:0];
        for (int k = 0; k < 4; k++)
        begin
            din.q[k] = s_tdata[4 + k * qalu_pkg::CW +: qalu_pkg::CW];
            din.r[k] = s_tdata[4 + (4 + k) * qalu_pkg::CW +: qalu_pkg::CW];
        end
        din.sc = s_tdata[4 + 8 * qalu_pkg::CW +: qalu_pkg::CW];
    end

    // The pipeline advances unless a full last stage meets a held result.
    assign en       = m_tready | ~out_vld_reg | ~last_vld;
    assign s_tready = en;

    qalu_prep u_prep (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (s_tvalid),
        .din     (din),
        .out_vld (prep_vld),
        .dout    (prep_out)
    );

    qalu_divsqrt u_divsqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (prep_vld),
        .din     (prep_out),
        .out_vld (ds_vld),
        .dout    (ds_out)
    );

    qalu_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (ds_vld),
        .din     (ds_out),
        .out_vld (last_vld),
        .dout    (last_res)
    );

    // Output register.
    always_comb
    begin
        if (en && last_vld)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && last_vld)
        begin
            out_reg <= last_res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = qalu_pkg::OUT_W'({out_reg.status, out_reg.norm, out_reg.res});

endmodule

// ----- rtl/quaternion_alu_checker.sv -----
// Port-level checker for the quaternion ALU and its bind to the top level.
// Uses qalu_pkg for the field positions in m_tdata.
module quaternion_alu_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [qalu_pkg::OUT_W-1:0]  m_tdata
);

    localparam int RESW = 4 * qalu_pkg::CW;
    localparam int STL  = qalu_pkg::OUT_RAW - 2;

    logic [1:0]                 st;
    logic [RESW-1:0]            res;
    logic [qalu_pkg::CW-2:0]    nrm;

    assign st  = m_tdata[STL +: 2];
    assign res = m_tdata[RESW-1:0];
    assign nrm = m_tdata[RESW +: qalu_pkg::CW-1];

    // A stalled result stays and holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The status code is never the unused value.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> st != 2'd3)
        else $error("unused status code");

    // A divide by zero returns an all-zero result.
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && st == qalu_pkg::ST_DZ |-> res == '0 && nrm == '0)
        else $error("non-zero result on divide by zero");

    // A non-zero norm only comes with a zero quaternion.
    a_norm_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && nrm != '0 |-> res == '0)
        else $error("norm and quaternion both non-zero");

    // m_tvalid does not rise straight out of reset.
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(rst_n))
        else $error("result raised straight out of reset");

endmodule

bind quaternion_alu quaternion_alu_checker u_quaternion_alu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- sim/tb_quaternion_alu.sv -----
// Self-checking testbench for the quaternion ALU stream block.
// A directed table, then random items; each checked against its typed or predicted result.
// Depends on qalu_pkg and quaternion_alu from the RTL.
`timescale 1ns / 1ps

module tb_quaternion_alu;

    localparam int WDOG_LIMIT = 20000;
    localparam int N_RANDOM   = 1100;
    localparam logic [31:0] MAXC = 32'h7fff_ffff;
    localparam logic [31:0] MINC = 32'h8000_0000;
    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam logic [31:0] ZC   = 32'd0;

    typedef struct packed {
        logic [3:0]         op;
        logic [3:0][31:0]   q;      // index 0 x, 1 y, 2 z, 3 w
        logic [3:0][31:0]   r;
        logic [31:0]        sc;
    } qitem_t;

    typedef struct packed {
        logic [3:0][31:0]   res;
        logic [30:0]        norm;
        logic [1:0]         status;
    } qres_t;

    typedef struct packed {
        qitem_t  it;
        logic    typed;
        qres_t   want;
    } row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [qalu_pkg::IN_W-1:0]   s_tdata;
    logic                        m_tvalid;
    logic                        m_tready;
    logic [qalu_pkg::OUT_W-1:0]  m_tdata;

    qres_t  pending_results [$];
    row_t   directed_rows [$];
    int     n_errors;
    int     n_sent;
    int     n_checked;
    int     idle_cycles;
    logic   rx_stall_mode;

    quaternion_alu dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock, 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Clamp a wide signed value into the component range.
    function automatic logic [31:0] clamp(input logic signed [67:0] v, inout bit hit);
        if (v > $signed({36'd0, MAXC}))
        begin
            hit = 1'b1;
            return MAXC;
        end
        if (v < -$signed(68'sh8000_0000))
        begin
            hit = 1'b1;
            return MINC;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [67:0] mulx(input logic [31:0] a, input logic [31:0] b);
        logic signed [67:0] sa;
        logic signed [67:0] sb;
        sa = {{36{a[31]}}, a};
        sb = {{36{b[31]}}, b};
        return sa * sb;
    endfunction

    // Hamilton product q*r with a floor shift of the exact sum.
    function automatic logic [3:0][31:0] hamilton_prod(input logic [3:0][31:0] a,
                                                       input logic [3:0][31:0] b,
                                                       inout bit hit);
        logic [3:0][31:0]   o;
        logic signed [67:0] s;
        s = mulx(a[1], b[2]) - mulx(a[2], b[1]) + mulx(a[0], b[3]) + mulx(a[3], b[0]);
        o[0] = clamp(s >>> qalu_pkg::FB, hit);
        s = mulx(a[2], b[0]) - mulx(a[0], b[2]) + mulx(a[1], b[3]) + mulx(a[3], b[1]);
        o[1] = clamp(s >>> qalu_pkg::FB, hit);
        s = mulx(a[0], b[1]) - mulx(a[1], b[0]) + mulx(a[2], b[3]) + mulx(a[3], b[2]);
        o[2] = clamp(s >>> qalu_pkg::FB, hit);
        s = mulx(a[3], b[3]) - mulx(a[0], b[0]) - mulx(a[1], b[1]) - mulx(a[2], b[2]);
        o[3] = clamp(s >>> qalu_pkg::FB, hit);
        return o;
    endfunction

    // Inverse: conjugate over the squared norm; returns 0 for a zero squared norm.
    function automatic bit quat_inverse(input logic [3:0][31:0] a,
                                        output logic [3:0][31:0] o, inout bit hit);
        logic signed [67:0] sum_sq;
        logic signed [67:0] sqn;
        logic signed [67:0] c;
        sum_sq = 0;
        o = '0;
        for (int k = 0; k < 4; k++)
            sum_sq = sum_sq + mulx(a[k], a[k]);
        sqn = sum_sq >>> qalu_pkg::FB;
        if (sqn == 0)
            return 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            c = {{36{a[k][31]}}, a[k]};
            if (k < 3)
                c = -c;
            o[k] = clamp((c <<< qalu_pkg::FB) / sqn, hit);
        end
        return 1'b1;
    endfunction

    // Integer square root, one result bit per step.
    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] b;
        root = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= root + b)
            begin
                n = n - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    // Expected result of one item.
    function automatic qres_t quat_predict(input qitem_t it);
        qres_t              o;
        logic [3:0][31:0]   t;
        logic signed [67:0] v;
        logic signed [67:0] scw;
        logic [67:0]        sum_sq;
        logic [63:0]        root;
        bit                 hit;
        bit                 dz;
        o = '0;
        hit = 1'b0;
        dz = 1'b0;
        scw = {{36{it.sc[31]}}, it.sc};
        case (it.op)
            qalu_pkg::OP_ADD, qalu_pkg::OP_SUB:
                for (int k = 0; k < 4; k++)
                begin
                    v = (it.op == qalu_pkg::OP_ADD) ?
                        $signed({{36{it.q[k][31]}}, it.q[k]})
                            + $signed({{36{it.r[k][31]}}, it.r[k]}) :
                        $signed({{36{it.q[k][31]}}, it.q[k]})
                            - $signed({{36{it.r[k][31]}}, it.r[k]});
                    o.res[k] = clamp(v, hit);
                end
            qalu_pkg::OP_MUL:
                o.res = hamilton_prod(it.q, it.r, hit);
            qalu_pkg::OP_DIV:
                if (quat_inverse(it.r, t, hit))
                    o.res = hamilton_prod(it.q, t, hit);
                else
                    dz = 1'b1;
            qalu_pkg::OP_SCALE:
                for (int k = 0; k < 4; k++)
                    o.res[k] = clamp(mulx(it.q[k], it.sc) >>> qalu_pkg::FB, hit);
            qalu_pkg::OP_DIVS:
                if (it.sc == 0)
                    dz = 1'b1;
                else
                    for (int k = 0; k < 4; k++)
                    begin
                        v = {{36{it.q[k][31]}}, it.q[k]};
                        o.res[k] = clamp((v <<< qalu_pkg::FB) / scw, hit);
                    end
            qalu_pkg::OP_SOVQ:
                if (quat_inverse(it.q, t, hit))
                begin
                    for (int k = 0; k < 4; k++)
                        o.res[k] = clamp(mulx(t[k], it.sc) >>> qalu_pkg::FB, hit);
                end
                else
                    dz = 1'b1;
            qalu_pkg::OP_CONJ:
            begin
                for (int k = 0; k < 3; k++)
                    o.res[k] = clamp(-$signed({{36{it.q[k][31]}}, it.q[k]}), hit);
                o.res[3] = it.q[3];
            end
            qalu_pkg::OP_INV:
                if (!quat_inverse(it.q, o.res, hit))
                    dz = 1'b1;
            qalu_pkg::OP_NORM:
            begin
                sum_sq = 0;
                for (int k = 0; k < 4; k++)
                    sum_sq = sum_sq + mulx(it.q[k], it.q[k]);
                // A sum that leaves 64 bits saturates the norm outright.
                if (sum_sq[67:64] != 0)
                    root = 64'h8000_0000;
                else
                    root = int_sqrt(sum_sq[63:0]);
                if (root > 64'h7fff_ffff)
                begin
                    root = 64'h7fff_ffff;
                    hit = 1'b1;
                end
                o.norm = root[30:0];
            end
            default:
                ;
        endcase
        if (dz)
        begin
            o.res = '0;
            o.status = qalu_pkg::ST_DZ;
        end
        else
            o.status = hit ? qalu_pkg::ST_SAT : qalu_pkg::ST_OK;
        return o;
    endfunction

    function automatic logic [qalu_pkg::IN_W-1:0] pack_item(input qitem_t it);
        logic [qalu_pkg::IN_W-1:0] d;
        d = '0;
        d[3:0] = it.op;
        for (int k = 0; k < 4; k++)
        begin
            d[4 + 32*k +: 32]   = it.q[k];
            d[132 + 32*k +: 32] = it.r[k];
        end
        d[260 +: 32] = it.sc;
        return d;
    endfunction

    function automatic row_t mk_row(input logic [3:0] op, input logic [3:0][31:0] q,
                                    input logic [3:0][31:0] r, input logic [31:0] sc,
                                    input logic typed, input qres_t want);
        row_t w;
        w.it.op = op;
        w.it.q = q;
        w.it.r = r;
        w.it.sc = sc;
        w.typed = typed;
        w.want = want;
        return w;
    endfunction

    function automatic qres_t mk_res(input logic [3:0][31:0] res, input logic [30:0] norm,
                                     input logic [1:0] st);
        qres_t w;
        w.res = res;
        w.norm = norm;
        w.status = st;
        return w;
    endfunction

    // Component value: mostly a few units, sometimes full range or an extreme.
    function automatic logic [31:0] rand_comp();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        if (sel < 70)
            return $signed($urandom_range(0, 32'h0000_0400)) - 32'sh0000_0200;
        if (sel < 90)
            return $urandom;
        if (sel < 94)
            return 32'd0;
        if (sel < 97)
            return MAXC;
        return MINC;
    endfunction

    function automatic qitem_t rand_item();
        qitem_t it;
        int     sel;
        sel = $urandom_range(0, 99);
        it.op = (sel < 96) ? 4'($urandom_range(0, 9)) : 4'($urandom_range(10, 15));
        for (int k = 0; k < 4; k++)
        begin
            it.q[k] = rand_comp();
            it.r[k] = rand_comp();
        end
        // Occasionally an all-zero operand to hit the zero divisor paths.
        if ($urandom_range(0, 24) == 0)
            it.q = '0;
        if ($urandom_range(0, 24) == 0)
            it.r = '0;
        it.sc = rand_comp();
        return it;
    endfunction

    // Gap length: mostly none or short, a few long.
    function automatic int rand_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return 0;
        if (sel < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // One transfer on the slave side: drive at the falling edge, hold until taken.
    // Returns at the falling edge after the transfer with s_tvalid still high.
    task automatic send_item(input qitem_t it, input logic typed, input qres_t want,
                             input bit use_gaps);
        int gap;
        gap = use_gaps ? rand_gap() : 0;
        repeat (gap)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_item(it);
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(typed ? want : quat_predict(it));
        n_sent++;
        @(negedge clk);
    endtask

    // Receiver readiness: alternating stretches of free flow and random stalls.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if ($urandom_range(0, 199) == 0)
                rx_stall_mode <= ~rx_stall_mode;
            if (!rx_stall_mode)
                m_tready <= 1'b1;
            else if (idle_cycles > 0)
                m_tready <= 1'b0;
            else
                m_tready <= ($urandom_range(0, 99) < 70);
        end
    end

    // Long receiver stalls now and then, counted down at the falling edge.
    always @(negedge clk)
    begin
        if (idle_cycles > 0)
            idle_cycles <= idle_cycles - 1;
        else if (rx_stall_mode && $urandom_range(0, 99) == 0)
            idle_cycles <= $urandom_range(5, 40);
    end

    // Result checking against the oldest outstanding expectation.
    always @(posedge clk)
    begin
        qres_t got;
        qres_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            for (int k = 0; k < 4; k++)
                got.res[k] = m_tdata[32*k +: 32];
            got.norm   = m_tdata[128 +: 31];
            got.status = m_tdata[159 +: 2];
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer: no item outstanding");
                n_errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                n_checked++;
                if (got.res[0] !== want.res[0])
                begin
                    $error("res_x: expected %h, got %h", want.res[0], got.res[0]);
                    n_errors++;
                end
                if (got.res[1] !== want.res[1])
                begin
                    $error("res_y: expected %h, got %h", want.res[1], got.res[1]);
                    n_errors++;
                end
                if (got.res[2] !== want.res[2])
                begin
                    $error("res_z: expected %h, got %h", want.res[2], got.res[2]);
                    n_errors++;
                end
                if (got.res[3] !== want.res[3])
                begin
                    $error("res_w: expected %h, got %h", want.res[3], got.res[3]);
                    n_errors++;
                end
                if (got.norm !== want.norm)
                begin
                    $error("norm_out: expected %h, got %h", want.norm, got.norm);
                    n_errors++;
                end
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: cycles without any transfer on either side.
    always @(posedge clk)
    begin
        int quiet;
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WDOG_LIMIT)
        begin
            $display("Watchdog expired with %0d results outstanding",
                     pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Main sequence: reset, directed table, a drain, random items, final drain.
    initial
    begin
        qres_t zres;
        row_t  w;
        zres = '0;
        n_errors = 0;
        n_sent = 0;
        n_checked = 0;
        idle_cycles = 0;
        rx_stall_mode = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;

        // Directed rows: zero divisors, extremes and every opcode.
        directed_rows.push_back(mk_row(qalu_pkg::OP_ADD, '0, '0, 0, 1, zres));
        directed_rows.push_back(mk_row(qalu_pkg::OP_ADD, {4{MAXC}}, {4{MAXC}}, 0, 1,
                                       mk_res({4{MAXC}}, 0, qalu_pkg::ST_SAT)));
        directed_rows.push_back(mk_row(qalu_pkg::OP_SUB, {4{MINC}}, {4{MAXC}}, 0, 1,
                                       mk_res({4{MINC}}, 0, qalu_pkg::ST_SAT)));
        directed_rows.push_back(mk_row(qalu_pkg::OP_SUB, {ONE, 32'hffff_0000, ONE, 32'd3},
                                       {32'd7, ONE, 32'd0, 32'hffff_fffe}, 0, 0, zres));
        directed_rows.push_back(mk_row(qalu_pkg::OP_MUL, {ONE, ZC, ZC, ZC},
                                       {ZC, ONE, ZC, ZC}, 0, 0, zres));
        directed_rows.push_back(mk_row(qalu_pkg::OP_MUL, {4{MINC}}, {4{MINC}}, 0, 0, zres));
        directed_rows.push_back(mk_row(qalu_pkg::OP_MUL, {4{MAXC}}, {4{MINC}}, 0, 0, zres));
        directed_rows.push_back(mk_row(qalu_pkg::OP_DIV, {4{ONE}}, '0, 0, 1,
                                       mk_res('0, 0, qalu_pkg::ST_DZ)));
        directed_rows.push_back(mk_row(qalu_pkg::OP_DIV, {4{ONE}}, {32'd1, ZC, ZC, 32'd1},
                                       0, 0, zres));
        directed_rows.push_back(mk_row(qalu_pkg::OP_DIV, {ONE, ONE, ZC, ONE},
                                       {ZC, ZC, ZC, 32'h0002_0000}, 0, 0, zres));
        directed_rows.push_back(mk_row(qalu_pkg::OP_SCALE, {4{MAXC}}, '0, MAXC, 1,
                                       mk_res({4{MAXC}}, 0, qalu_pkg::ST_SAT)));
        directed_rows.push_back(mk_row(qalu_pkg::OP_SCALE, {MINC, ONE, 32'hffff_0000, 32'd5},
                                       '0, 32'hfffe_8000, 0, zres));
        directed_rows.push_back(mk_row(qalu_pkg::OP_DIVS, {4{ONE}}, '0, 0, 1,
                                       mk_res('0, 0, qalu_pkg::ST_DZ)));
        directed_rows.push_back(mk_row(qalu_pkg::OP_DIVS, {MAXC, MINC, ONE, 32'd7}, '0,
                                       32'd1, 0, zres));
        directed_rows.push_back(mk_row(qalu_pkg::OP_DIVS, {MINC, MAXC, 32'd9, 32'hffff_fff9},
                                       '0, 32'hffff_ffff, 0, zres));
        directed_rows.push_back(mk_row(qalu_pkg::OP_SOVQ, '0, '0, ONE, 1,
                                       mk_res('0, 0, qalu_pkg::ST_DZ)));
        directed_rows.push_back(mk_row(qalu_pkg::OP_SOVQ, {ZC, ZC, ZC, 32'h0000_0100}, '0,
                                       MAXC, 0, zres));
        directed_rows.push_back(mk_row(qalu_pkg::OP_CONJ, {MINC, MAXC, ONE, MINC}, '0, 0, 1,
                                       mk_res({MINC, 32'h8000_0001, 32'hffff_0000, MAXC},
                                              0, qalu_pkg::ST_SAT)));
        directed_rows.push_back(mk_row(qalu_pkg::OP_INV, '0, '0, 0, 1,
                                       mk_res('0, 0, qalu_pkg::ST_DZ)));
        directed_rows.push_back(mk_row(qalu_pkg::OP_INV, {ZC, ZC, ZC, 32'd256}, '0, 0, 0,
                                       zres));
        directed_rows.push_back(mk_row(qalu_pkg::OP_INV, {4{MINC}}, '0, 0, 0, zres));
        directed_rows.push_back(mk_row(qalu_pkg::OP_NORM, {ZC, ZC, ZC, ONE}, '0, 0, 1,
                                       mk_res('0, 31'h0001_0000, qalu_pkg::ST_OK)));
        directed_rows.push_back(mk_row(qalu_pkg::OP_NORM, {4{MINC}}, '0, 0, 1,
                                       mk_res('0, 31'h7fff_ffff, qalu_pkg::ST_SAT)));
        directed_rows.push_back(mk_row(qalu_pkg::OP_NORM, {MAXC, MAXC, MINC, ZC}, '0, 0, 0,
                                       zres));
        directed_rows.push_back(mk_row(4'd15, {4{MAXC}}, {4{MINC}}, MAXC, 1, zres));

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            w = directed_rows[i];
            send_item(w.it, w.typed, w.want, (i % 2) == 1);
        end
        s_tvalid <= 1'b0;

        // Hold the sender off until every directed result has been returned.
        while (pending_results.size() != 0)
            @(negedge clk);

        // Random part: bursts without gaps alternate with gapped stretches.
        for (int i = 0; i < N_RANDOM; i++)
            send_item(rand_item(), 1'b0, zres, ((i / 100) % 3) != 0);
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);

        $display("Covered %0d items (directed table, then random over all opcodes);", n_sent);
        $display("%0d results checked field by field, %0d mismatches.", n_checked, n_errors);
        if (n_errors == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
